@@ sv/sync_frame_angle_decoder_unit_macros.svh @@
// Assertion macros for the sync frame angle decoder
`ifndef SYNC_FRAME_ANGLE_DECODER_UNIT_MACROS_SVH
`define SYNC_FRAME_ANGLE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define SFAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/sfad_pkg.sv @@
// Package: types, constants and angle function of the sync frame angle decoder
`default_nettype none
package sfad_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'h55;
   localparam logic [7:0]  SYNC_SECOND = 8'hAA;
   localparam logic [7:0]  CMD_ANGLE   = 8'h06;
   localparam logic [34:0] ANGLE_LIMIT = 35'd61440;
   localparam logic [34:0] ANGLE_WRAP  = 35'd122880;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_SYNC2 = 3'd2,
      PH_DATA  = 3'd3,
      PH_CSUM  = 3'd4
   } phase_type;

   // completed frame handed from parser to output stage
   typedef struct packed {
      logic        fire;
      logic [31:0] value;
      logic        ok;
   } frame_type;

   // angle in 1/1024 degree: 3*v, or 3*(v - wrap) above the limit, mod 2^35
   function automatic logic signed [34:0] angle_of(input logic [31:0] v);
      logic [34:0] x;
      logic [34:0] d;
      x = {3'b000, v};
      d = (x <= ANGLE_LIMIT) ? x : (x - ANGLE_WRAP);
      return $signed(d + {d[33:0], 1'b0});
   endfunction

endpackage
`default_nettype wire

@@ sv/sfad_parser.sv @@
// Frame parser: header hunt, data shift, running checksum
`default_nettype none
module sfad_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   output sfad_pkg::phase_type    phase,
   output sfad_pkg::frame_type    frame
);
   import sfad_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  sum_ff, sum_in;
   logic        clear_frame;
   logic        shift_byte;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
            end
            PH_SYNC1: begin
               if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC1;
               else if (rx_byte == SYNC_SECOND) phase_in = PH_SYNC2;
               else phase_in = PH_IDLE;
            end
            PH_SYNC2: begin
               if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC1;
               else if (rx_byte == CMD_ANGLE) phase_in = PH_DATA;
               else phase_in = PH_IDLE;
            end
            PH_DATA: begin
               phase_in = (count_ff == 2'd3) ? PH_CSUM : PH_DATA;
            end
            PH_CSUM: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      clear_frame = 1'b0;
      shift_byte  = 1'b0;
      frame.fire  = 1'b0;
      case (phase_ff)
         PH_SYNC2: begin
            clear_frame = accept && (rx_byte == CMD_ANGLE);
         end
         PH_DATA: begin
            shift_byte = accept;
         end
         PH_CSUM: begin
            frame.fire = accept;
         end
         default: begin
            clear_frame = 1'b0;
         end
      endcase
      frame.value = value_ff;
      frame.ok    = (rx_byte == sum_ff);
   end

   always_comb begin
      count_in = count_ff;
      value_in = value_ff;
      sum_in   = sum_ff;
      if (clear_frame) begin
         count_in = 2'd0;
         value_in = 32'd0;
         sum_in   = CMD_ANGLE;
      end else if (shift_byte) begin
         count_in = count_ff + 2'd1;
         value_in = {value_ff[23:0], rx_byte};
         sum_in   = sum_ff + rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 2'd0;
         value_ff <= 32'd0;
         sum_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         value_ff <= value_in;
         sum_ff   <= sum_in;
      end
   end

   assign phase = phase_ff;

endmodule
`default_nettype wire

@@ sv/sync_frame_angle_decoder_unit.sv @@
// Sync frame angle decoder: takes one byte per clock, finds 55 AA 06 frames
// with four big-endian data bytes and a sum checksum, and returns one word per
// frame with the value, the checksum flag and the angle in 1/1024 degree.
// The result word is registered and shows in the cycle after the checksum
// byte is taken. The input stalls only when a checksum byte arrives while
// the previous result word is still held.
`default_nettype none
module sync_frame_angle_decoder_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [31:0]        rsp_frame_value,
   output      logic               rsp_checksum_ok,
   output      logic signed [34:0] rsp_angle_q10
);
   import sfad_pkg::*;
   `include "sync_frame_angle_decoder_unit_macros.svh"

   phase_type          phase;
   frame_type          frame;
   logic               accept;
   logic               valid_ff, valid_in;
   logic [31:0]        value_ff;
   logic               ok_ff;
   logic signed [34:0] angle_ff;

   assign req_ready = !valid_ff || rsp_ready || (phase != PH_CSUM);
   assign accept    = req_valid && req_ready;

   sfad_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .phase   (phase),
      .frame   (frame)
   );

   always_comb begin
      if (frame.fire) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.fire) begin
         value_ff <= frame.value;
         ok_ff    <= frame.ok;
         angle_ff <= angle_of(frame.value);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_value = value_ff;
   assign rsp_checksum_ok = ok_ff;
   assign rsp_angle_q10   = angle_ff;

   `SFAD_ASSERT_NOW(a_stall_only_full, clock, reset,
      !req_ready, valid_ff && !rsp_ready, "input stalled without a held word")
   `SFAD_ASSERT_NOW(a_no_overwrite, clock, reset,
      frame.fire, !valid_ff || rsp_ready, "result word overwritten")
   `SFAD_ASSERT_NEXT(a_fire_shows, clock, reset,
      frame.fire, valid_ff && (value_ff == $past(frame.value)), "frame not presented")

endmodule
`default_nettype wire
